@@ src/xrcd_pkg.sv @@
`default_nettype none

package xrcd_pkg;

	// decoder phase, one per kind of byte expected next
	typedef enum logic [2:0] {
		PH_CTRL      = 3'd0,
		PH_REP_CHAR  = 3'd1,
		PH_REP_ATTR  = 3'd2,
		PH_CELL_CHAR = 3'd3,
		PH_CELL_ATTR = 3'd4
	} phase_t;

	// sequencer around the shared cell step
	typedef enum logic [1:0] {
		SQ_IDLE   = 2'd0,
		SQ_DECODE = 2'd1,
		SQ_EMIT   = 2'd2
	} seq_t;

	// run methods from bits 7..6 of a control byte
	localparam logic [1:0] RM_NONE = 2'd0;
	localparam logic [1:0] RM_CHAR = 2'd1;
	localparam logic [1:0] RM_ATTR = 2'd2;
	localparam logic [1:0] RM_BOTH = 2'd3;

	// register indexes
	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	localparam int unsigned MAX_WIDTH_DEF = 160;

	localparam logic        MODE_RST   = 1'b1;
	localparam logic [7:0]  WIDTH_RST  = 8'd80;
	localparam logic [15:0] HEIGHT_RST = 16'd25;

endpackage

`default_nettype wire

@@ src/xbin_rle_cell_decoder.sv @@
`default_nettype none

// Run-length decoder for the image data of an extended-binary text picture. Bytes come in
// on the s_ side one word at a time and character cells leave on the m_ side, one word per
// cell, tlast on the last cell a byte causes and tuser on the cell that fills the picture.
// A byte is taken while the sequencer is idle and decoded in the cycle after; its cells
// then go out one per cycle while the m_ side does not stall, since a single cell counter
// and index compare steps one cell at a time, and no new byte is taken until they are done
// or the picture is full. A control byte of method "both repeated" with count c gives up to
// c + 1 cells from one attribute byte, so s_tready stays low while those cells are issued
// and while the m_ side stalls. Cells beyond width (clamped to MAX_WIDTH) times height are
// dropped without a word. The cfg port writes a register on any clock edge with cfg_we high;
// it is meant to be written only while no byte is in flight.
module xbin_rle_cell_decoder #(
	parameter int unsigned MAX_WIDTH = xrcd_pkg::MAX_WIDTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // data_byte
	input  wire        s_tuser,   // start_image
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [39:0] m_tdata,  // char_code[7:0], fg_color[11:8], bg_color[15:12],
	                              // cell_index[39:16]
	output logic       m_tlast,   // last_of_run
	output logic       m_tuser,   // image_done
	input  wire        cfg_we,
	input  wire  [1:0] cfg_addr,
	input  wire  [15:0] cfg_wdata
);

	// registers
	logic        mode_q;
	logic [7:0]  width_q;
	logic [15:0] height_q;

	logic [7:0]  width_eff;
	logic [23:0] total_q;

	xrcd_pkg::seq_t   seq_q, seq_d;
	xrcd_pkg::phase_t phase_q;
	logic [1:0]  method_q;
	logic [6:0]  left_q;
	logic [7:0]  held_char_q;
	logic [7:0]  held_attr_q;
	logic [23:0] emitted_q;

	logic [7:0]  byte_q;
	logic        start_q;

	// pending cells of the current byte
	logic [6:0]  run_cnt_q;
	logic [7:0]  run_char_q;
	logic [7:0]  run_attr_q;

	// output word
	logic        out_valid_q;
	logic [7:0]  out_char_q;
	logic [3:0]  out_fg_q;
	logic [3:0]  out_bg_q;
	logic [23:0] out_idx_q;
	logic        out_last_q;
	logic        out_done_q;

	// decoder next values
	xrcd_pkg::phase_t eff_phase, phase_d;
	logic [1:0]  eff_method, method_d;
	logic [6:0]  eff_left, left_d;
	logic [7:0]  eff_char, char_d;
	logic [7:0]  eff_attr, attr_d;
	logic [6:0]  run_cnt_d;
	logic [7:0]  run_char_d;
	logic [7:0]  run_attr_d;

	logic        accept;
	logic        out_free;
	logic        pic_full;
	logic        cell_done;
	logic        cell_last;
	logic        emit_go;
	logic        decode_en;
	logic [23:0] emitted_inc;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign width_eff = (32'(width_q) > 32'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : width_q;

	always_ff @(posedge clk) begin
		total_q <= {16'd0, width_eff} * {8'd0, height_q};
	end

	// shared cell step: one increment and compare per cell
	assign emitted_inc = emitted_q + 24'd1;
	assign pic_full    = emitted_q >= total_q;
	assign cell_done   = emitted_inc == total_q;
	assign cell_last   = (run_cnt_q == 7'd1) || cell_done;

	// decoder
	always_comb begin
		if (start_q) begin
			eff_phase  = xrcd_pkg::PH_CTRL;
			eff_method = xrcd_pkg::RM_NONE;
			eff_left   = 7'd0;
			eff_char   = 8'd0;
			eff_attr   = 8'd0;
		end else begin
			eff_phase  = phase_q;
			eff_method = method_q;
			eff_left   = left_q;
			eff_char   = held_char_q;
			eff_attr   = held_attr_q;
		end

		phase_d    = eff_phase;
		method_d   = eff_method;
		left_d     = eff_left;
		char_d     = eff_char;
		attr_d     = eff_attr;
		run_cnt_d  = 7'd0;
		run_char_d = eff_char;
		run_attr_d = byte_q;

		if (!mode_q) begin
			if (eff_phase == xrcd_pkg::PH_CELL_ATTR) begin
				run_cnt_d = 7'd1;
				phase_d   = xrcd_pkg::PH_CELL_CHAR;
			end else begin
				char_d  = byte_q;
				phase_d = xrcd_pkg::PH_CELL_ATTR;
			end
		end else begin
			unique case (eff_phase)
				xrcd_pkg::PH_REP_CHAR: begin
					char_d  = byte_q;
					phase_d = (eff_method == xrcd_pkg::RM_BOTH) ?
						xrcd_pkg::PH_REP_ATTR : xrcd_pkg::PH_CELL_ATTR;
				end
				xrcd_pkg::PH_REP_ATTR: begin
					attr_d = byte_q;
					if (eff_method == xrcd_pkg::RM_BOTH) begin
						run_cnt_d = eff_left;
						left_d    = 7'd0;
						phase_d   = xrcd_pkg::PH_CTRL;
					end else begin
						phase_d = xrcd_pkg::PH_CELL_CHAR;
					end
				end
				xrcd_pkg::PH_CELL_CHAR: begin
					if (eff_method == xrcd_pkg::RM_ATTR) begin
						run_cnt_d  = 7'd1;
						run_char_d = byte_q;
						run_attr_d = eff_attr;
					end else begin
						char_d  = byte_q;
						phase_d = xrcd_pkg::PH_CELL_ATTR;
					end
				end
				xrcd_pkg::PH_CELL_ATTR: begin
					run_cnt_d = 7'd1;
				end
				default: begin
					// control byte, also taken for unused phase codes
					method_d = byte_q[7:6];
					left_d   = {1'b0, byte_q[5:0]} + 7'd1;
					if (byte_q[7:6] == xrcd_pkg::RM_NONE) begin
						phase_d = xrcd_pkg::PH_CELL_CHAR;
					end else if (byte_q[7:6] == xrcd_pkg::RM_ATTR) begin
						phase_d = xrcd_pkg::PH_REP_ATTR;
					end else begin
						phase_d = xrcd_pkg::PH_REP_CHAR;
					end
				end
			endcase

			// single cell of a run: step the run on
			if (run_cnt_d == 7'd1 && (eff_phase == xrcd_pkg::PH_CELL_ATTR ||
					eff_phase == xrcd_pkg::PH_CELL_CHAR)) begin
				if (eff_left <= 7'd1) begin
					left_d  = 7'd0;
					phase_d = xrcd_pkg::PH_CTRL;
				end else begin
					left_d  = eff_left - 7'd1;
					phase_d = (eff_method == xrcd_pkg::RM_CHAR) ?
						xrcd_pkg::PH_CELL_ATTR : xrcd_pkg::PH_CELL_CHAR;
				end
			end
		end
	end

	// sequencer next state
	always_comb begin
		seq_d = seq_q;
		unique case (seq_q)
			xrcd_pkg::SQ_IDLE: begin
				if (accept) begin
					seq_d = xrcd_pkg::SQ_DECODE;
				end
			end
			xrcd_pkg::SQ_DECODE: begin
				seq_d = (run_cnt_d != 7'd0) ? xrcd_pkg::SQ_EMIT : xrcd_pkg::SQ_IDLE;
			end
			xrcd_pkg::SQ_EMIT: begin
				if (pic_full) begin
					seq_d = xrcd_pkg::SQ_IDLE;
				end else if (out_free && cell_last) begin
					seq_d = xrcd_pkg::SQ_IDLE;
				end
			end
			default: begin
				seq_d = xrcd_pkg::SQ_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		decode_en = 1'b0;
		emit_go   = 1'b0;
		unique case (seq_q)
			xrcd_pkg::SQ_IDLE:   s_tready  = 1'b1;
			xrcd_pkg::SQ_DECODE: decode_en = 1'b1;
			xrcd_pkg::SQ_EMIT:   emit_go   = !pic_full && out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= xrcd_pkg::SQ_IDLE;
			mode_q      <= xrcd_pkg::MODE_RST;
			width_q     <= xrcd_pkg::WIDTH_RST;
			height_q    <= xrcd_pkg::HEIGHT_RST;
			phase_q     <= xrcd_pkg::PH_CTRL;
			method_q    <= xrcd_pkg::RM_NONE;
			left_q      <= 7'd0;
			held_char_q <= 8'd0;
			held_attr_q <= 8'd0;
			emitted_q   <= 24'd0;
			run_cnt_q   <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			seq_q <= seq_d;

			if (decode_en) begin
				phase_q     <= phase_d;
				method_q    <= method_d;
				left_q      <= left_d;
				held_char_q <= char_d;
				held_attr_q <= attr_d;
				run_cnt_q   <= run_cnt_d;
				if (start_q) begin
					emitted_q <= 24'd0;
				end
			end

			if (emit_go) begin
				emitted_q <= emitted_inc;
				run_cnt_q <= run_cnt_q - 7'd1;
			end

			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_addr)
					xrcd_pkg::CFG_MODE: begin
						// new mode restarts the decoder, cell count kept
						mode_q   <= cfg_wdata[0];
						phase_q  <= xrcd_pkg::PH_CTRL;
						method_q <= xrcd_pkg::RM_NONE;
						left_q   <= 7'd0;
					end
					xrcd_pkg::CFG_WIDTH:  width_q  <= cfg_wdata[7:0];
					xrcd_pkg::CFG_HEIGHT: height_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q  <= s_tdata;
			start_q <= s_tuser;
		end
		if (decode_en) begin
			run_char_q <= run_char_d;
			run_attr_q <= run_attr_d;
		end
		if (emit_go) begin
			out_char_q <= run_char_q;
			out_fg_q   <= run_attr_q[3:0];
			out_bg_q   <= run_attr_q[7:4];
			out_idx_q  <= emitted_q;
			out_last_q <= cell_last;
			out_done_q <= cell_done;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_idx_q, out_bg_q, out_fg_q, out_char_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_done_q;

	a_no_cell_past_picture: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |-> emitted_q < total_q)
		else $error("cell issued past end of picture");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("picture-filling cell not marked last");

	a_emit_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == xrcd_pkg::SQ_EMIT |-> run_cnt_q != 7'd0)
		else $error("emitting with no cells pending");

	a_last_ends_byte: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go && cell_last |=> seq_q == xrcd_pkg::SQ_IDLE)
		else $error("sequencer kept going after last cell");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> emitted_q == $past(emitted_q) + 24'd1)
		else $error("cell count did not step by one");

endmodule

`default_nettype wire

@@ dv/tb_xbin_rle_cell_decoder.sv @@
`timescale 1ns / 1ps

module tb_xbin_rle_cell_decoder;
	import xrcd_pkg::*;

	localparam int unsigned WIDTH_CAP = MAX_WIDTH_DEF;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int N_ROWS = 26;
	localparam int N_SETTINGS = 9;

	typedef struct packed {
		logic [7:0]  ch;
		logic [3:0]  fg;
		logic [3:0]  bg;
		logic [23:0] idx;
		logic        last;
		logic        done;
	} cell_t;

	// directed row; typed rows carry the cell count and the last cell of that byte
	typedef struct packed {
		logic [7:0]  data;
		logic        start;
		logic        typed;
		logic [6:0]  n;
		logic [7:0]  ch;
		logic [3:0]  fg;
		logic [3:0]  bg;
		logic [23:0] idx;
	} row_t;

	typedef struct packed {
		logic        mode;
		logic [7:0]  w;
		logic [15:0] h;
		logic [7:0]  items;
		logic        quiet;
		logic [1:0]  bursts;
	} setting_t;

	localparam row_t DIR_ROWS [N_ROWS] = '{
		'{8'h00, 1'b1, 1'b1, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h41, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h1f, 1'b0, 1'b1, 7'd1,  8'h41, 4'hf, 4'h1, 24'd0},
		'{8'h42, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'hff, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h00, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'hff, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h80, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h81, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'ha5, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h00, 1'b0, 1'b1, 7'd1,  8'h00, 4'h5, 4'ha, 24'd4},
		'{8'h7e, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'hff, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h20, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h07, 1'b0, 1'b1, 7'd64, 8'h20, 4'h7, 4'h0, 24'd69},
		'{8'hc0, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h00, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h00, 1'b0, 1'b1, 7'd1,  8'h00, 4'h0, 4'h0, 24'd70},
		'{8'hc1, 1'b1, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h78, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h9c, 1'b0, 1'b1, 7'd2,  8'h78, 4'hc, 4'h9, 24'd1},
		'{8'h05, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h33, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		// restart in the middle of an unfinished run
		'{8'hc0, 1'b1, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h11, 1'b0, 1'b0, 7'd0,  8'h00, 4'h0, 4'h0, 24'd0},
		'{8'h22, 1'b0, 1'b1, 7'd1,  8'h11, 4'h2, 4'h2, 24'd0}
	};

	// width 0 and height 0 give empty pictures, widths above the cap are clamped
	localparam setting_t RUN_SETTINGS [N_SETTINGS] = '{
		'{1'b1, 8'd160, 16'd65535, 8'd40, 1'b0, 2'd2},
		'{1'b1, 8'd3,   16'd2,     8'd30, 1'b0, 2'd0},
		'{1'b0, 8'd200, 16'd1,     8'd30, 1'b1, 2'd0},
		'{1'b0, 8'd1,   16'd1,     8'd20, 1'b0, 2'd0},
		'{1'b1, 8'd0,   16'd5,     8'd15, 1'b0, 2'd1},
		'{1'b1, 8'd7,   16'd0,     8'd15, 1'b0, 2'd1},
		'{1'b1, 8'd255, 16'd1,     8'd25, 1'b1, 2'd3},
		'{1'b0, 8'd160, 16'd65535, 8'd30, 1'b0, 2'd0},
		'{1'b1, 8'd4,   16'd3,     8'd25, 1'b0, 2'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = CFG_MODE;
	logic [15:0] cfg_wdata = 16'h0000;

	// decoder copy
	logic        rle_mode = MODE_RST;
	logic [7:0]  pic_w = WIDTH_RST;
	logic [15:0] pic_h = HEIGHT_RST;
	phase_t      cur_phase = PH_CTRL;
	logic [1:0]  run_meth = RM_NONE;
	logic [6:0]  run_left = 7'd0;
	logic [7:0]  held_ch = 8'h00;
	logic [7:0]  held_at = 8'h00;
	logic [23:0] cells_out = 24'd0;

	cell_t       pending_cells[$];
	int          step_cells;
	int          err_cnt = 0;
	int          n_bytes = 0;
	int          n_cells = 0;
	int          cycles = 0;
	int          rx_stall = 0;
	bit          idle_on = 1'b1;

	xbin_rle_cell_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // data_byte
		.s_tuser   (s_tuser),   // start_image
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // char_code, fg_color, bg_color, cell_index
		.m_tlast   (m_tlast),   // last_of_run
		.m_tuser   (m_tuser),   // image_done
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic int unsigned picture_size();
		int unsigned w;
		w = (32'(pic_w) > WIDTH_CAP) ? WIDTH_CAP : 32'(pic_w);
		return w * pic_h;
	endfunction

	task automatic put_cell(input logic [7:0] ch, input logic [7:0] attr);
		int unsigned total;
		cell_t c;
		total = picture_size();
		if (cells_out >= total || step_cells >= 64)
			return;
		c.ch = ch;
		c.fg = attr[3:0];
		c.bg = attr[7:4];
		c.idx = cells_out;
		c.last = 1'b0;
		c.done = (cells_out + 1 == total);
		pending_cells.push_back(c);
		cells_out = cells_out + 24'd1;
		step_cells++;
	endtask

	task automatic end_run_cell();
		if (run_left <= 7'd1) begin
			run_left = 7'd0;
			cur_phase = PH_CTRL;
		end else begin
			run_left = run_left - 7'd1;
			cur_phase = (run_meth == RM_CHAR) ? PH_CELL_ATTR : PH_CELL_CHAR;
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic st);
		cell_t tail;
		step_cells = 0;
		if (st) begin
			cur_phase = PH_CTRL;
			run_meth = RM_NONE;
			run_left = 7'd0;
			held_ch = 8'h00;
			held_at = 8'h00;
			cells_out = 24'd0;
		end
		if (!rle_mode) begin
			if (cur_phase == PH_CELL_ATTR) begin
				put_cell(held_ch, b);
				cur_phase = PH_CELL_CHAR;
			end else begin
				held_ch = b;
				cur_phase = PH_CELL_ATTR;
			end
		end else begin
			case (cur_phase)
				PH_REP_CHAR: begin
					held_ch = b;
					cur_phase = (run_meth == RM_BOTH) ? PH_REP_ATTR : PH_CELL_ATTR;
				end
				PH_REP_ATTR: begin
					held_at = b;
					if (run_meth == RM_BOTH) begin
						for (int k = 0; k < run_left; k++)
							put_cell(held_ch, held_at);
						run_left = 7'd0;
						cur_phase = PH_CTRL;
					end else begin
						cur_phase = PH_CELL_CHAR;
					end
				end
				PH_CELL_CHAR: begin
					if (run_meth == RM_ATTR) begin
						put_cell(b, held_at);
						end_run_cell();
					end else begin
						held_ch = b;
						cur_phase = PH_CELL_ATTR;
					end
				end
				PH_CELL_ATTR: begin
					put_cell(held_ch, b);
					end_run_cell();
				end
				default: begin
					run_meth = b[7:6];
					run_left = {1'b0, b[5:0]} + 7'd1;
					if (run_meth == RM_NONE)
						cur_phase = PH_CELL_CHAR;
					else if (run_meth == RM_ATTR)
						cur_phase = PH_REP_ATTR;
					else
						cur_phase = PH_REP_CHAR;
				end
			endcase
		end
		if (step_cells > 0) begin
			tail = pending_cells.pop_back();
			tail.last = 1'b1;
			pending_cells.push_back(tail);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic st);
		int gap;
		gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= st;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_byte(b, st);
		n_bytes++;
	endtask

	// registers written in turn, mode first, then width and height
	task automatic apply_settings(input setting_t s);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_MODE;
		cfg_wdata <= {15'd0, s.mode};
		@(posedge clk);
		cfg_addr <= CFG_WIDTH;
		cfg_wdata <= {8'd0, s.w};
		@(posedge clk);
		cfg_addr <= CFG_HEIGHT;
		cfg_wdata <= s.h;
		@(posedge clk);
		cfg_we <= 1'b0;
		rle_mode = s.mode;
		pic_w = s.w;
		pic_h = s.h;
		cur_phase = PH_CTRL;
		run_meth = RM_NONE;
		run_left = 7'd0;
	endtask

	// compressed: mostly whole packets with random payload, some stray or cut short
	task automatic rand_packet();
		int roll;
		int cnt;
		int follow;
		logic [1:0] meth;
		logic st;
		roll = $urandom_range(0, 99);
		st = ($urandom_range(0, 29) == 0);
		if (!rle_mode || roll < 10) begin
			send_byte(8'($urandom_range(0, 255)), st);
		end else begin
			meth = 2'($urandom_range(0, 3));
			cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
			send_byte({meth, cnt[5:0]}, st);
			case (meth)
				RM_NONE: follow = 2 * (cnt + 1);
				RM_BOTH: follow = 2;
				default: follow = cnt + 2;
			endcase
			if (roll < 16)
				follow = $urandom_range(0, follow - 1);
			repeat (follow)
				send_byte(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	// a byte whose cells are all dropped still keeps the block busy with nothing on the output
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin : cell_sink
		cell_t want;
		cell_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[7:0], m_tdata[11:8], m_tdata[15:12], m_tdata[39:16],
				m_tlast, m_tuser};
			n_cells++;
			if (pending_cells.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected word idx %0d ch %h", $time, got.idx, got.ch);
			end else begin
				want = pending_cells.pop_front();
				if (got !== want) begin
					err_cnt++;
					$display("%0t: mismatch expected ch %h fg %h bg %h idx %0d last %b done %b",
						$time, want.ch, want.fg, want.bg, want.idx, want.last, want.done);
					$display("%0t:          actual   ch %h fg %h bg %h idx %0d last %b done %b",
						$time, got.ch, got.fg, got.bg, got.idx, got.last, got.done);
				end
			end
		end
		if (rx_stall != 0) begin
			m_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			rx_stall <= pick_gap() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		row_t row;
		setting_t s;
		int goal;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			row = DIR_ROWS[i];
			send_byte(row.data, row.start);
			if (row.typed) begin
				if (step_cells != row.n || (row.n != 0 &&
					(pending_cells[$].ch != row.ch || pending_cells[$].fg != row.fg ||
					pending_cells[$].bg != row.bg || pending_cells[$].idx != row.idx))) begin
					err_cnt++;
					$display("%0t: row %0d expected %0d cells, last ch %h fg %h bg %h idx %0d",
						$time, i, row.n, row.ch, row.fg, row.bg, row.idx);
					$display("%0t: row %0d predicted %0d cells", $time, i, step_cells);
				end
			end
		end

		for (int p = 0; p < N_SETTINGS; p++) begin
			s = RUN_SETTINGS[p];
			wait_idle();
			apply_settings(s);
			idle_on = !s.quiet;
			if (s.mode) begin
				repeat (s.bursts) begin
					send_byte({RM_BOTH, 6'h3f}, 1'b0);
					send_byte(8'($urandom_range(0, 255)), 1'b0);
					send_byte(8'($urandom_range(0, 255)), 1'b0);
				end
			end
			goal = n_bytes + s.items;
			while (n_bytes < goal)
				rand_packet();
		end

		wait_idle();
		$display("covered %0d bytes and %0d cells over %0d register settings", n_bytes,
			n_cells, N_SETTINGS + 1);
		$display("incl. raw pairs, clamped width, empty and overfilled pictures, restarts");
		if (err_cnt == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
